// ----- hw/rtl/btk_pkg.sv -----
// Package for the bounded top-k table: field widths, opcodes, payload and command types.
`default_nettype none

package btk_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SCORE_BITS  = 16;
    localparam int TAG_BITS    = 16;
    localparam int OPCODE_BITS = 2;
    localparam int RIDX_BITS   = 4;
    localparam int CAP_BITS    = 5;
    localparam int COUNT_BITS  = 5;
    localparam int POS_BITS    = 4;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [OPCODE_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [SCORE_BITS-1:0]  score;
        logic [TAG_BITS-1:0]    payload_tag;
        logic [RIDX_BITS-1:0]   read_index;
    } in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] entry_count;
        logic                  inserted;
        logic [POS_BITS-1:0]   insert_position;
        logic                  read_valid;
        logic [SCORE_BITS-1:0] read_score;
        logic [TAG_BITS-1:0]   read_tag;
    } out_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/btk_ctrl.sv -----
// Controller state machine: accepts a transaction, then runs it once the result register is free.
`default_nettype none

module btk_ctrl
    import btk_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.load_in = s_valid && (state_reg == ST_IDLE);
    assign cmd.exec    = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load_in) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.exec) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set on a finished item, drop once the receiver takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_goes_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not move to execute");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("executed item did not present a result");

    a_blocked_exec_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && m_valid_reg && !m_ready)
        |=> ((state_reg == ST_EXEC) && m_valid_reg))
        else $error("item executed over an untaken result");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/btk_datapath.sv -----
// Datapath: sorted entry cells, fill count, capacity register, input and result registers.
`default_nettype none

module btk_datapath
    import btk_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    input  wire in_t                 s_data,
    output out_t                     m_data,
    input  wire logic                cfg_we,
    input  wire logic [CAP_BITS-1:0] cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CMPW   = (CNT_W > RIDX_BITS) ? CNT_W : RIDX_BITS;

    logic [SCORE_BITS-1:0] score_reg [MAX_ENTRIES];
    logic [TAG_BITS-1:0]   tag_reg   [MAX_ENTRIES];
    logic [SCORE_BITS-1:0] prev_score [MAX_ENTRIES];
    logic [TAG_BITS-1:0]   prev_tag   [MAX_ENTRIES];

    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_after;
    logic [CNT_W-1:0]    fill_inc;
    logic [CNT_W-1:0]    cap_eff;
    logic [CNT_W-1:0]    pos;
    logic [CAP_BITS-1:0] cap_reg;
    in_t                 in_reg;
    out_t                out_reg;
    out_t                out_next;

    logic [MAX_ENTRIES-1:0] ahead;
    logic [MAX_ENTRIES-1:0] at;
    logic                   do_ins;
    logic                   rd_ok;
    logic [IDX_W-1:0]       rd_idx;

    assign cap_eff = (cap_reg > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cap_reg);

    // Entries ahead of the new one; sorted order makes this a thermometer code.
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ahead[i] = (CNT_W'(i) < fill_reg) && !(in_reg.score > score_reg[i]);
        end
        at = ~ahead & {ahead[MAX_ENTRIES-2:0], 1'b1};
    end

    always_comb begin
        pos = CNT_W'(MAX_ENTRIES);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (at[i]) begin
                pos = CNT_W'(i);
            end
        end
    end

    always_comb begin
        prev_score[0] = in_reg.score;
        prev_tag[0]   = in_reg.payload_tag;
        for (int i = 1; i < MAX_ENTRIES; i++) begin
            prev_score[i] = score_reg[i-1];
            prev_tag[i]   = tag_reg[i-1];
        end
    end

    assign do_ins   = (in_reg.opcode == OP_ADD) && (pos < cap_eff);
    assign fill_inc = (fill_reg < cap_eff) ? fill_reg + CNT_W'(1) : fill_reg;
    assign rd_ok    = (in_reg.opcode == OP_READ) && (CMPW'(in_reg.read_index) < CMPW'(fill_reg));
    assign rd_idx   = IDX_W'(in_reg.read_index);

    always_comb begin
        fill_after = fill_reg;
        case (in_reg.opcode)
            OP_ADD: begin
                if (do_ins) begin
                    fill_after = fill_inc;
                end
            end
            OP_CLEAR: begin
                fill_after = '0;
            end
            default: begin
                fill_after = fill_reg;
            end
        endcase
    end

    always_comb begin
        out_next                 = '0;
        out_next.entry_count     = COUNT_BITS'(fill_after);
        out_next.inserted        = do_ins;
        out_next.insert_position = do_ins ? POS_BITS'(pos) : '0;
        out_next.read_valid      = rd_ok;
        if (rd_ok) begin
            out_next.read_score = score_reg[rd_idx];
            out_next.read_tag   = tag_reg[rd_idx];
        end
    end

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            cap_reg  <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg  <= cfg_wdata;
            fill_reg <= '0;
        end else if (cmd.exec) begin
            fill_reg <= fill_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    // Each cell below the insertion point takes its upper neighbour; the one at it takes the new entry.
    always_ff @(posedge aclk) begin
        if (cmd.exec && do_ins) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (!ahead[i]) begin
                    score_reg[i] <= at[i] ? in_reg.score : prev_score[i];
                    tag_reg[i]   <= at[i] ? in_reg.payload_tag : prev_tag[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_top_k_sorted_insert_top.sv -----
// Top level of the bounded top-k table: controller and datapath joined by commands.
//
// Keeps up to capacity entries (score, tag) sorted highest score first.
// Input channel s_valid/s_ready/s_data carries one transaction per item:
//   add (insert before the first strictly lower score, ties keep arrival order,
//   last entry drops out when full), read at an index, or clear.
// Result channel m_valid/m_ready/m_data returns exactly one transaction per item.
// Configuration: cfg_we with cfg_wdata writes capacity and empties the table;
//   write it only while the block is idle.
// Flow: an item is accepted in the idle state and executed in the execute state,
//   in which every entry cell compares and shifts in parallel; the result register
//   and its valid flag are loaded when execution completes. A new item is accepted
//   only after the current one has executed.
// The next transaction is accepted while a result still waits; its execution
//   then holds until the result register is free, so a stalled receiver stalls
//   the input after one item.
// Reset (aresetn low, synchronous): table empty, capacity 16, no result pending.
`default_nettype none

module bounded_top_k_sorted_insert_top
    import btk_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_t                 s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_t                     m_data,
    input  wire logic                cfg_we,
    input  wire logic [CAP_BITS-1:0] cfg_wdata
);

    cmd_t cmd;

    // Sequence accept and execute; own the result valid flag.
    btk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold the sorted entries and compute each result.
    btk_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// ----- tb/tb_bounded_top_k_sorted_insert_top.sv -----
// Self-checking testbench for the bounded top-k table: directed table, random phases, predictor.
`default_nettype none

module tb_bounded_top_k_sorted_insert_top;
    import btk_pkg::*;

    localparam int TABLE_DEPTH   = MAX_ENTRIES;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 30;
    localparam int DIRECTED_ROWS = 32;
    localparam int PENDING_DEPTH = 8;

    // Opcode 3 is not in the package; the block treats it as a no-op.
    localparam logic [OPCODE_BITS-1:0] OP_NOP = 2'd3;

    // One row of the directed table: a capacity write or a transaction, the
    // latter optionally carrying a hand-written expected result.
    typedef struct {
        logic                is_cfg;
        logic [CAP_BITS-1:0] cap;
        in_t                 item;
        logic                typed;
        out_t                want;
    } step_row_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_t                 s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_t                m_data;
    logic                cfg_we    = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;

    bounded_top_k_sorted_insert_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Shadow copy of the table, its fill level and the capacity register.
    logic [SCORE_BITS-1:0] shadow_score [TABLE_DEPTH];
    logic [TAG_BITS-1:0]   shadow_tag   [TABLE_DEPTH];
    int                    shadow_fill;
    logic [CAP_BITS-1:0]   shadow_cap;

    // Expected results in flight, held as a small ring.
    out_t      pending_results [PENDING_DEPTH];
    int        pend_head  = 0;
    int        pend_tail  = 0;
    int        pend_count = 0;

    step_row_t directed [DIRECTED_ROWS];
    int        n_directed = 0;

    int n_items        = 0;
    int n_results      = 0;
    int n_errors       = 0;
    int n_inserts      = 0;
    int n_drops        = 0;
    int n_valid_reads  = 0;
    int n_cap_settings = 0;
    int burst_left     = 0;
    int cycle_count    = 0;
    int stall_timer    = 0;
    logic [1:0] stall_mode = 2'd0;

    // Apply one transaction to the shadow table and return the result it
    // should produce.
    function automatic out_t table_update(in_t it);
        out_t r;
        int   eff;
        int   pos;
        int   i;
        r   = '0;
        eff = (shadow_cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_cap);
        if (shadow_fill > eff)
            shadow_fill = eff;
        case (it.opcode)
            OP_ADD: begin
                // Walk past every entry that is not strictly lower, so ties
                // keep their arrival order.
                pos = 0;
                while (pos < shadow_fill && !(it.score > shadow_score[pos]))
                    pos++;
                if (pos < eff) begin
                    if (shadow_fill < eff)
                        shadow_fill++;
                    // Shift the tail down; a full table drops its last entry.
                    for (i = shadow_fill - 1; i > pos; i--) begin
                        shadow_score[i] = shadow_score[i-1];
                        shadow_tag[i]   = shadow_tag[i-1];
                    end
                    shadow_score[pos]  = it.score;
                    shadow_tag[pos]    = it.payload_tag;
                    r.inserted         = 1'b1;
                    r.insert_position  = pos[POS_BITS-1:0];
                end
            end
            OP_READ: begin
                if (int'(it.read_index) < shadow_fill) begin
                    r.read_valid = 1'b1;
                    r.read_score = shadow_score[it.read_index];
                    r.read_tag   = shadow_tag[it.read_index];
                end
            end
            OP_CLEAR: shadow_fill = 0;
            default: ;
        endcase
        r.entry_count = shadow_fill[COUNT_BITS-1:0];
        return r;
    endfunction

    function automatic step_row_t chk(in_t it);
        step_row_t r;
        r = '{1'b0, '0, it, 1'b0, '0};
        return r;
    endfunction

    function automatic step_row_t fix(in_t it, out_t want);
        step_row_t r;
        r = '{1'b0, '0, it, 1'b1, want};
        return r;
    endfunction

    function automatic step_row_t cap_row(logic [CAP_BITS-1:0] c);
        step_row_t r;
        r = '{1'b1, c, '0, 1'b0, '0};
        return r;
    endfunction

    task automatic add_step(step_row_t r);
        directed[n_directed] = r;
        n_directed++;
    endtask

    task automatic queue_result(out_t r);
        pending_results[pend_tail] = r;
        pend_tail = (pend_tail + 1) % PENDING_DEPTH;
        pend_count++;
    endtask

    // Random transaction, weighted towards adds so the table fills and the
    // full-table paths (tail drop, discard) get most of the traffic.
    function automatic in_t random_item();
        in_t it;
        int  pick;
        it.score       = SCORE_BITS'($urandom);
        it.payload_tag = TAG_BITS'($urandom);
        it.read_index  = RIDX_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.opcode = OP_ADD;
        else if (pick < 92)
            it.opcode = OP_READ;
        else if (pick < 96)
            it.opcode = OP_CLEAR;
        else
            it.opcode = OP_NOP;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: it.score = '0;
                    1: it.score = '1;
                    2: it.score = 16'h8000;
                    default: begin
                        // Tie with the lowest stored entry.
                        if (shadow_fill > 0)
                            it.score = shadow_score[shadow_fill-1];
                    end
                endcase
            end
            1: it.score = SCORE_BITS'($urandom_range(0, 7));
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0)
            it.read_index = RIDX_BITS'($urandom_range(0, (shadow_fill > 15) ? 15 : shadow_fill));
        return it;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (n_errors < PRINT_LIMIT)
            $display("[%0d] result %0d %s: got 0x%0h, expected 0x%0h",
                     cycle_count, n_results, what, got, want);
        n_errors++;
    endtask

    task automatic check_result(out_t got);
        out_t want;
        if (pend_count == 0) begin
            report_mismatch("unexpected result", got.entry_count, 0);
            return;
        end
        want = pending_results[pend_head];
        pend_head = (pend_head + 1) % PENDING_DEPTH;
        pend_count--;
        n_results++;
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.inserted !== want.inserted)
            report_mismatch("inserted", got.inserted, want.inserted);
        if (got.insert_position !== want.insert_position)
            report_mismatch("insert_position", got.insert_position, want.insert_position);
        if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.read_score !== want.read_score)
            report_mismatch("read_score", got.read_score, want.read_score);
        if (got.read_tag !== want.read_tag)
            report_mismatch("read_tag", got.read_tag, want.read_tag);
    endtask

    // Offer one transaction and hold it until accepted; the shadow table
    // advances at the accepting edge.
    task automatic send_item(in_t it, logic typed, out_t want);
        out_t predicted;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = table_update(it);
        queue_result(typed ? want : predicted);
        n_items++;
        if (it.opcode == OP_ADD) begin
            if (predicted.inserted)
                n_inserts++;
            else
                n_drops++;
        end
        if (predicted.read_valid)
            n_valid_reads++;
    endtask

    // Sender bursts: count down the current burst, then idle for a while.
    task automatic pace_sender();
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pend_count != 0);
    endtask

    // Capacity is written only with nothing in flight; the write also
    // empties the table.
    task automatic write_capacity(logic [CAP_BITS-1:0] c);
        wait_until_drained();
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        shadow_cap  = c;
        shadow_fill = 0;
        n_cap_settings++;
    endtask

    // Result side: check each accepted transaction, then pick the next
    // ready value from the current stall mode.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result(m_data);
        if (stall_timer == 0) begin
            stall_mode  <= 2'($urandom_range(0, 3));
            stall_timer <= $urandom_range(20, 80);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_timer[3:0] < 4'd3);
        endcase
    end

    // Watchdog: give up if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pend_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int                  phase;
        int                  len;
        int                  k;
        int                  n_random;
        logic [CAP_BITS-1:0] c;
        phase       = 0;
        n_random    = 0;
        shadow_fill = 0;
        shadow_cap  = CAP_RESET;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            shadow_score[k] = '0;
            shadow_tag[k]   = '0;
        end

        // Directed part. Capacity starts at its reset value of 16.
        // Reads of an empty table, at both ends of the index range.
        add_step(fix(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd0},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_READ, 16'hFFFF, 16'hFFFF, 4'd15},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        // Score extremes: the top score leads, zero goes behind it.
        add_step(fix(in_t'{OP_ADD, 16'hFFFF, 16'hFFFF, 4'd0},
                     out_t'{5'd1, 1'b1, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_ADD, 16'h0000, 16'h0000, 4'd0},
                     out_t'{5'd2, 1'b1, 4'd1, 1'b0, 16'h0, 16'h0}));
        // Two equal scores: the later one lands behind the earlier.
        add_step(chk(in_t'{OP_ADD, 16'h8000, 16'h1234, 4'd0}));
        add_step(chk(in_t'{OP_ADD, 16'h8000, 16'h5678, 4'd0}));
        add_step(chk(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd1}));
        add_step(chk(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd2}));
        add_step(chk(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd3}));
        // Read one past the count.
        add_step(chk(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd4}));
        add_step(chk(in_t'{OP_NOP, 16'hFFFF, 16'hFFFF, 4'd15}));
        add_step(fix(in_t'{OP_CLEAR, 16'hFFFF, 16'hFFFF, 4'd15},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd0},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        // Capacity one: full after the first add; lower and equal scores are
        // discarded, a higher one replaces the entry.
        add_step(cap_row(5'd1));
        add_step(fix(in_t'{OP_ADD, 16'h1000, 16'hAAAA, 4'd0},
                     out_t'{5'd1, 1'b1, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_ADD, 16'h0FFF, 16'h5555, 4'd0},
                     out_t'{5'd1, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_ADD, 16'h1000, 16'hBBBB, 4'd0},
                     out_t'{5'd1, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_ADD, 16'hFFFF, 16'h0001, 4'd0},
                     out_t'{5'd1, 1'b1, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd0},
                     out_t'{5'd1, 1'b0, 4'd0, 1'b1, 16'hFFFF, 16'h0001}));
        // Capacity zero: nothing is ever stored.
        add_step(cap_row(5'd0));
        add_step(fix(in_t'{OP_ADD, 16'hFFFF, 16'hFFFF, 4'd0},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(fix(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd0},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));
        // Capacity above the table depth behaves as the full depth.
        add_step(cap_row(5'd31));
        add_step(fix(in_t'{OP_ADD, 16'h0001, 16'h0F0F, 4'd0},
                     out_t'{5'd1, 1'b1, 4'd0, 1'b0, 16'h0, 16'h0}));
        add_step(chk(in_t'{OP_READ, 16'h0000, 16'h0000, 4'd0}));
        add_step(fix(in_t'{OP_CLEAR, 16'h0000, 16'h0000, 4'd0},
                     out_t'{5'd0, 1'b0, 4'd0, 1'b0, 16'h0, 16'h0}));

        // Hold reset low at the start, then release it for good.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < n_directed; k++) begin
            if (directed[k].is_cfg) begin
                write_capacity(directed[k].cap);
            end else begin
                pace_sender();
                send_item(directed[k].item, directed[k].typed, directed[k].want);
            end
        end

        // Random phases, each under its own capacity: the extremes first,
        // then random settings. Halfway through each phase drain the block.
        while (n_random < RANDOM_ITEMS) begin
            case (phase)
                0: c = 5'd16;
                1: c = 5'd2;
                2: c = 5'd31;
                3: c = 5'd1;
                4: c = 5'd0;
                5: c = 5'd16;
                default: c = CAP_BITS'($urandom_range(0, 31));
            endcase
            write_capacity(c);
            len = (c == 5'd0) ? 40 : 150;
            for (k = 0; k < len; k++) begin
                pace_sender();
                send_item(random_item(), 1'b0, '0);
                n_random++;
                if (k == len / 2)
                    wait_until_drained();
            end
            phase++;
        end

        wait_until_drained();
        repeat (6) @(posedge aclk);

        $display("Covered %0d transactions over %0d capacity settings: %0d stored, %0d discarded,",
                 n_items, n_cap_settings, n_inserts, n_drops);
        $display("%0d valid reads, %0d results checked, %0d mismatches.",
                 n_valid_reads, n_results, n_errors);
        if (n_errors == 0 && pend_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/btk_pkg.sv
hw/rtl/btk_ctrl.sv
hw/rtl/btk_datapath.sv
hw/rtl/bounded_top_k_sorted_insert_top.sv
tb/tb_bounded_top_k_sorted_insert_top.sv
